@@ sv/alle_pkg.sv @@
// ----------------------------------------------------------------------------
// alle_pkg
// shared types of the array linked list engine: command codes, sequencer
// states and the control word that travels from the front to the back
// ----------------------------------------------------------------------------
package alle_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_LINK,
		ST_FIND_RD,
		ST_FIND_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t cmd;
		logic in_range;
	} item_ctl_t;

	localparam logic [7:0] COUNT_SAT = 8'hFF;

endpackage

@@ sv/alle_front.sv @@
// ----------------------------------------------------------------------------
// alle_front
// accepts command beats, checks the slot against the store depth and keeps
// them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module alle_front #(
	parameter int DEPTH      = 256,
	parameter int VALUE_BITS = 32,
	parameter int AW         = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            command,
	input  logic [7:0]            slot,
	input  logic [31:0]           data_word,
	input  logic                  clearing,
	input  logic                  take,
	output logic                  q_valid,
	output alle_pkg::item_ctl_t   q_ctl,
	output logic [AW-1:0]         q_idx,
	output logic [VALUE_BITS-1:0] q_key
);
	import alle_pkg::*;

	item_ctl_t             ctl_q [2];
	logic [AW-1:0]         idx_q [2];
	logic [VALUE_BITS-1:0] key_q [2];
	logic                  wr_ptr_q, rd_ptr_q;
	logic [1:0]            fill_q;
	logic                  push, pop;
	item_ctl_t             cls;

	// classify the incoming beat
	always_comb begin
		cls.cmd      = cmd_t'(command);
		cls.in_range = (32'(slot) < 32'(DEPTH));
	end

	assign item_stall = (fill_q == 2'd2) || clearing;
	assign push       = item_valid && !item_stall;
	assign q_valid    = (fill_q != 2'd0);
	assign pop        = q_valid && take;
	assign q_ctl      = ctl_q[rd_ptr_q];
	assign q_idx      = idx_q[rd_ptr_q];
	assign q_key      = key_q[rd_ptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q] <= cls;
			idx_q[wr_ptr_q] <= AW'(slot);
			key_q[wr_ptr_q] <= VALUE_BITS'(data_word);
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd2) |-> !push) else $error("queue overflow");
	a_no_push_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !push) else $error("beat taken during clear");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3) else $error("queue fill out of range");

endmodule

@@ sv/alle_back.sv @@
// ----------------------------------------------------------------------------
// alle_back
// sequencer over the link, value and in-use memories; clears the links after
// reset, carries out one command at a time and holds the result register
// ----------------------------------------------------------------------------
module alle_back #(
	parameter int DEPTH      = 256,
	parameter int VALUE_BITS = 32,
	parameter int AW         = 8,
	parameter int CW         = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  alle_pkg::item_ctl_t   q_ctl,
	input  logic [AW-1:0]         q_idx,
	input  logic [VALUE_BITS-1:0] q_key,
	output logic                  take,
	output logic                  clearing,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  status,
	output logic [7:0]            new_slot,
	output logic [31:0]           read_word,
	output logic [7:0]            entry_count
);
	import alle_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	// memories
	logic [AW-1:0]         nxt_mem [DEPTH];
	logic [AW-1:0]         prv_mem [DEPTH];
	logic [VALUE_BITS-1:0] val_mem [DEPTH];
	logic                  use_mem [DEPTH];

	logic [AW-1:0]         nxt_rd, prv_rd;
	logic [VALUE_BITS-1:0] val_rd;
	logic                  use_rd;

	logic [AW-1:0]         nxt_ra, prv_ra, val_ra, use_ra;
	logic                  nxt_we, prv_we, val_we, use_we;
	logic [AW-1:0]         nxt_wa, prv_wa, val_wa, use_wa;
	logic [AW-1:0]         nxt_wd, prv_wd;
	logic                  use_wd;

	state_t                state_q, state_d;
	cmd_t                  cmd_q;
	logic                  range_q;
	logic [AW-1:0]         idx_q, free_q, n_q, after_q, cur_q, clr_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [CW-1:0]         cnt_q;
	logic [AW:0]           steps_q;
	logic                  res_fail_q;
	logic [31:0]           res_word_q;
	logic                  ok_ins, ok_rem, ok_get, out_free, matched;

	// command checks on the read data
	assign ok_ins   = range_q && use_rd && (free_q != '0);
	assign ok_rem   = range_q && use_rd && (idx_q != '0);
	assign ok_get   = ok_rem;
	assign out_free = !result_valid || !result_stall;
	assign matched  = (val_rd == key_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (clr_q == LAST) state_d = ST_IDLE;
			ST_IDLE:     if (q_valid) state_d = ST_READ;
			ST_READ:     state_d = ST_CHECK;
			ST_CHECK: begin
				case (cmd_q)
					CMD_INSERT: state_d = ok_ins ? ST_LINK : ST_DONE;
					CMD_REMOVE: state_d = ok_rem ? ST_LINK : ST_DONE;
					CMD_FIND:   state_d = ST_FIND_RD;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_LINK:     state_d = ST_DONE;
			ST_FIND_RD: begin
				if ((cur_q == '0) || (32'(steps_q) >= 32'(DEPTH))) state_d = ST_DONE;
				else state_d = ST_FIND_CMP;
			end
			ST_FIND_CMP: state_d = matched ? ST_DONE : ST_FIND_RD;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_CLEAR;
		endcase
	end

	// memory control
	always_comb begin
		take     = (state_q == ST_IDLE);
		clearing = (state_q == ST_CLEAR);
		nxt_ra = idx_q;
		prv_ra = idx_q;
		val_ra = idx_q;
		use_ra = idx_q;
		nxt_we = 1'b0; nxt_wa = idx_q; nxt_wd = '0;
		prv_we = 1'b0; prv_wa = idx_q; prv_wd = '0;
		val_we = 1'b0; val_wa = free_q;
		use_we = 1'b0; use_wa = idx_q; use_wd = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				nxt_we = 1'b1; nxt_wa = clr_q; nxt_wd = '0;
				prv_we = 1'b1; prv_wa = clr_q;
				prv_wd = ((clr_q == '0) || (clr_q == LAST)) ? '0 : clr_q + 1'b1;
				use_we = 1'b1; use_wa = clr_q; use_wd = (clr_q == '0);
			end
			ST_READ: begin
				if (cmd_q == CMD_FIND) nxt_ra = '0;
				if (cmd_q == CMD_INSERT) prv_ra = free_q;
			end
			ST_CHECK: begin
				if (cmd_q == CMD_INSERT && ok_ins) begin
					nxt_we = 1'b1; nxt_wa = idx_q;  nxt_wd = free_q;
					prv_we = 1'b1; prv_wa = free_q; prv_wd = idx_q;
					val_we = 1'b1; val_wa = free_q;
					use_we = 1'b1; use_wa = free_q; use_wd = 1'b1;
				end
				if (cmd_q == CMD_REMOVE && ok_rem) begin
					nxt_we = 1'b1; nxt_wa = prv_rd; nxt_wd = nxt_rd;
					prv_we = 1'b1; prv_wa = nxt_rd; prv_wd = prv_rd;
					use_we = 1'b1; use_wa = idx_q;  use_wd = 1'b0;
				end
			end
			ST_LINK: begin
				if (cmd_q == CMD_INSERT) begin
					nxt_we = 1'b1; nxt_wa = n_q;     nxt_wd = after_q;
					prv_we = 1'b1; prv_wa = after_q; prv_wd = n_q;
				end else begin
					nxt_we = 1'b1; nxt_wa = idx_q; nxt_wd = '0;
					prv_we = 1'b1; prv_wa = idx_q; prv_wd = free_q;
				end
			end
			ST_FIND_RD: begin
				nxt_ra = cur_q;
				val_ra = cur_q;
			end
			default: ;
		endcase
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		nxt_rd <= nxt_mem[nxt_ra];
	end

	always_ff @(posedge clk) begin
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		prv_rd <= prv_mem[prv_ra];
	end

	always_ff @(posedge clk) begin
		if (val_we) val_mem[val_wa] <= key_q;
		val_rd <= val_mem[val_ra];
	end

	always_ff @(posedge clk) begin
		if (use_we) use_mem[use_wa] <= use_wd;
		use_rd <= use_mem[use_ra];
	end

	// command payload and scratch registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			cmd_q      <= q_ctl.cmd;
			range_q    <= q_ctl.in_range;
			idx_q      <= q_idx;
			key_q      <= q_key;
			res_fail_q <= 1'b1;
			res_word_q <= '0;
		end
		if (state_q == ST_CHECK) begin
			n_q     <= free_q;
			after_q <= nxt_rd;
			cur_q   <= nxt_rd;
			steps_q <= '0;
			if ((cmd_q == CMD_INSERT && ok_ins) || (cmd_q == CMD_REMOVE && ok_rem))
				res_fail_q <= 1'b0;
			if (cmd_q == CMD_GET && ok_get) begin
				res_fail_q <= 1'b0;
				res_word_q <= 32'(val_rd);
			end
		end
		if (state_q == ST_FIND_CMP) begin
			if (matched) res_fail_q <= 1'b0;
			cur_q   <= nxt_rd;
			steps_q <= steps_q + 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			free_q       <= AW'(1);
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_CHECK && cmd_q == CMD_INSERT && ok_ins) begin
				free_q <= prv_rd;
				cnt_q  <= cnt_q + 1'b1;
			end
			if (state_q == ST_LINK && cmd_q == CMD_REMOVE) begin
				free_q <= idx_q;
				if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
			end
			if (state_q == ST_DONE && out_free) result_valid <= 1'b1;
			else if (!result_stall) result_valid <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			status      <= res_fail_q;
			new_slot    <= (cmd_q == CMD_INSERT && !res_fail_q) ? 8'(n_q) : 8'd0;
			read_word   <= res_word_q;
			entry_count <= (32'(cnt_q) > 32'(COUNT_SAT)) ? COUNT_SAT : 8'(cnt_q);
		end
	end

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && cmd_q == CMD_INSERT && ok_ins)
		|=> cnt_q == $past(cnt_q) + 1'b1) else $error("insert count slip");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) < 32'(DEPTH)) else $error("entry count above capacity");
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(steps_q) <= 32'(DEPTH) || state_q != ST_FIND_CMP)
		else $error("find walk past bound");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("pending result dropped");

endmodule

@@ sv/array_linked_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// array_linked_list_engine_core
// doubly linked list in slot memories with a free stack; front queue and
// back sequencer
// ----------------------------------------------------------------------------
//  channel  | signals                                      | handshake
//  ---------+----------------------------------------------+---------------
//  item     | command, slot, data_word                     | item_valid / item_stall
//  result   | status, new_slot, read_word, entry_count     | result_valid / result_stall
//
//  every command passes the read, check and done states of the sequencer; a good
//  insert or remove also passes the link state (second link write)
//  find walks the list with one link and value read per list entry visited,
//  until a match, the end of the list or the walk bound
//  after reset a clearing pass over every slot sets up links; item_stall is high
//  the front queue holds two beats so items are taken while a command runs
//  a result waits in its output register under result_stall; the sequencer
//  holds its finished command until that register is free
// ----------------------------------------------------------------------------
module array_linked_list_engine_core #(
	parameter int DEPTH      = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  slot,
	input  logic [31:0] data_word,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        status,
	output logic [7:0]  new_slot,
	output logic [31:0] read_word,
	output logic [7:0]  entry_count
);
	import alle_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                  q_valid, take, clearing;
	item_ctl_t             q_ctl;
	logic [AW-1:0]         q_idx;
	logic [VALUE_BITS-1:0] q_key;

	alle_front #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS), .AW(AW)) u_front (
		.clk, .arst_n, .item_valid, .item_stall, .command, .slot, .data_word,
		.clearing, .take, .q_valid, .q_ctl, .q_idx, .q_key
	);

	alle_back #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS), .AW(AW), .CW(CW)) u_back (
		.clk, .arst_n, .q_valid, .q_ctl, .q_idx, .q_key, .take, .clearing,
		.result_valid, .result_stall, .status, .new_slot, .read_word, .entry_count
	);

endmodule

@@ bench/array_linked_list_engine_core_tb.sv @@
// ----------------------------------------------------------------------------
// array_linked_list_engine_core_tb
// self-checking bench for the slot-memory linked list engine: a generator
// builds directed and phased random command streams while tracking the list
// state, a valid/stall driver and monitor move the beats, and every result
// beat is compared field by field against the predicted one
// ----------------------------------------------------------------------------
module array_linked_list_engine_core_tb;
	import alle_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 256;
	localparam logic [7:0] SENTINEL = 8'd0;
	localparam int TARGET_ITEMS = 1250;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		cmd_t        cmd;
		logic [7:0]  slot;
		logic [31:0] word;
	} list_cmd_t;

	typedef struct {
		logic        status;
		logic [7:0]  new_slot;
		logic [31:0] read_word;
		logic [7:0]  entry_count;
	} list_resp_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  command;
	logic [7:0]  slot;
	logic [31:0] data_word;
	logic        result_valid;
	logic        result_stall;
	logic        status;
	logic [7:0]  new_slot;
	logic [31:0] read_word;
	logic [7:0]  entry_count;

	// shadow of the list state
	logic [31:0] val_mem [SLOTS];
	logic [7:0]  fwd [SLOTS];
	logic [7:0]  back [SLOTS];
	bit          used [SLOTS];
	logic [7:0]  free_top;
	int          live_cnt;

	list_cmd_t  cmd_list [$];
	list_resp_t resp_q [$];
	int         drive_idx;
	int         gap_left;
	int         stall_left;
	int         resp_seen;
	int         errors;

	array_linked_list_engine_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.slot         (slot),
		.data_word    (data_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.new_slot     (new_slot),
		.read_word    (read_word),
		.entry_count  (entry_count)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch on result %0d: %s got %0h expected %0h", resp_seen, what, got, want);
	endtask

	function automatic void clear_list();
		for (int i = 0; i < SLOTS; i++) begin
			fwd[i] = 8'd0;
			back[i] = (i == 0 || i == SLOTS - 1) ? 8'd0 : 8'(i + 1);
			used[i] = 1'b0;
		end
		used[0] = 1'b1;
		free_top = 8'd1;
		live_cnt = 0;
	endfunction

	// apply one command to the shadow list and return its response beat
	function automatic list_resp_t apply_cmd(list_cmd_t c);
		list_resp_t r;
		logic [7:0] n;
		logic [7:0] after;
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] cur;
		bit ok;
		ok = used[c.slot];
		r.status = 1'b1;
		r.new_slot = 8'd0;
		r.read_word = 32'd0;
		case (c.cmd)
			CMD_INSERT: begin
				if (ok && free_top != 8'd0) begin
					n = free_top;
					free_top = back[n];
					val_mem[n] = c.word;
					used[n] = 1'b1;
					after = fwd[c.slot];
					fwd[c.slot] = n;
					back[n] = c.slot;
					fwd[n] = after;
					back[after] = n;
					live_cnt++;
					r.status = 1'b0;
					r.new_slot = n;
				end
			end
			CMD_REMOVE: begin
				if (ok && c.slot != SENTINEL) begin
					p = back[c.slot];
					q = fwd[c.slot];
					fwd[p] = q;
					back[q] = p;
					used[c.slot] = 1'b0;
					fwd[c.slot] = 8'd0;
					back[c.slot] = free_top;
					free_top = c.slot;
					if (live_cnt > 0) live_cnt--;
					r.status = 1'b0;
				end
			end
			CMD_GET: begin
				if (ok && c.slot != SENTINEL) begin
					r.status = 1'b0;
					r.read_word = val_mem[c.slot];
				end
			end
			default: begin
				cur = fwd[0];
				for (int k = 0; k < SLOTS && cur != 8'd0; k++) begin
					if (val_mem[cur] == c.word) begin
						r.status = 1'b0;
						break;
					end
					cur = fwd[cur];
				end
			end
		endcase
		r.entry_count = (live_cnt > 255) ? COUNT_SAT : 8'(live_cnt);
		return r;
	endfunction

	function automatic void add_cmd(cmd_t cmd, logic [7:0] s, logic [31:0] w);
		list_cmd_t c;
		c.cmd = cmd;
		c.slot = s;
		c.word = w;
		cmd_list.push_back(c);
		resp_q.push_back(apply_cmd(c));
	endfunction

	function automatic logic [7:0] pick_live();
		int r;
		if (live_cnt == 0) return SENTINEL;
		r = $urandom_range(1, SLOTS - 1);
		while (!used[r]) r = (r == SLOTS - 1) ? 1 : r + 1;
		return 8'(r);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 2))
			0: return $urandom;
			1: return 32'($urandom_range(0, 15));
			default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000 | $urandom_range(0, 3);
		endcase
	endfunction

	// one random command; grow/shrink bias sets the insert and remove shares
	function automatic void rand_cmd(int ins_pct, int rem_pct);
		int roll;
		cmd_t cmd;
		logic [7:0] s;
		logic [31:0] w;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct) cmd = CMD_INSERT;
		else if (roll < ins_pct + rem_pct) cmd = CMD_REMOVE;
		else if (roll < ins_pct + rem_pct + (100 - ins_pct - rem_pct) / 2) cmd = CMD_GET;
		else cmd = CMD_FIND;
		if ($urandom_range(0, 99) < 85)
			s = (cmd == CMD_INSERT && $urandom_range(0, 5) == 0) ? SENTINEL : pick_live();
		else
			s = 8'($urandom_range(0, SLOTS - 1));
		w = pick_word();
		if (cmd == CMD_FIND && live_cnt > 0 && $urandom_range(0, 99) < 60)
			w = val_mem[pick_live()];
		add_cmd(cmd, s, w);
	endfunction

	// stimulus generation and end of test
	initial begin
		int phase;
		errors = 0;
		clear_list();
		// directed: sentinel, free slots, empty find, extremes, reuse
		add_cmd(CMD_GET, SENTINEL, 32'd0);
		add_cmd(CMD_REMOVE, SENTINEL, 32'd0);
		add_cmd(CMD_GET, 8'd5, 32'd0);
		add_cmd(CMD_REMOVE, 8'hFF, 32'd0);
		add_cmd(CMD_INSERT, 8'd7, 32'h1234_5678);
		add_cmd(CMD_FIND, 8'hFF, 32'd0);
		add_cmd(CMD_INSERT, SENTINEL, 32'd0);
		add_cmd(CMD_INSERT, SENTINEL, 32'hFFFF_FFFF);
		add_cmd(CMD_INSERT, 8'd1, 32'h8000_0001);
		add_cmd(CMD_GET, 8'd1, 32'hFFFF_FFFF);
		add_cmd(CMD_GET, 8'd2, 32'd0);
		add_cmd(CMD_FIND, 8'd0, 32'hFFFF_FFFF);
		add_cmd(CMD_FIND, 8'hAA, 32'h0001_2345);
		add_cmd(CMD_FIND, 8'h55, 32'd0);
		add_cmd(CMD_REMOVE, 8'd3, 32'hA5A5_A5A5);
		add_cmd(CMD_GET, 8'd3, 32'd0);
		add_cmd(CMD_INSERT, 8'd1, 32'h5A5A_5A5A);
		add_cmd(CMD_REMOVE, 8'd3, 32'd0);
		add_cmd(CMD_REMOVE, 8'd1, 32'd0);
		add_cmd(CMD_INSERT, 8'hFF, 32'hDEAD_BEEF);
		add_cmd(CMD_GET, 8'hFF, 32'd0);
		add_cmd(CMD_FIND, 8'd0, 32'h0000_0000);
		// random phases; phase 3 fills the store to its limit
		phase = 0;
		while (cmd_list.size() < TARGET_ITEMS) begin
			if (phase == 3) begin
				while (live_cnt < SLOTS - 1) add_cmd(CMD_INSERT, pick_live(), pick_word());
				for (int i = 0; i < 4; i++) add_cmd(CMD_INSERT, pick_live(), pick_word());
				for (int i = 0; i < 30; i++) rand_cmd(20, 0);
			end else begin
				for (int i = 0; i < 100; i++) begin
					case (phase % 3)
						0: rand_cmd(55, 15);
						1: rand_cmd(15, 55);
						default: rand_cmd(35, 35);
					endcase
				end
			end
			phase++;
		end
		wait (arst_n && drive_idx == cmd_list.size() && resp_q.size() == 0);
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("array_linked_list_engine_core test passed");
		else
			$display("array_linked_list_engine_core test failed");
		$finish;
	end

	// run limit
	initial begin
		#60_000_000;
		$display("array_linked_list_engine_core test failed");
		$finish;
	end

	// item driver; gaps drawn per beat, none in a middle stretch
	always @(posedge clk or negedge arst_n) begin
		int nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			command <= 2'd0;
			slot <= 8'd0;
			data_word <= 32'd0;
			drive_idx <= 0;
			gap_left <= 0;
		end else begin
			nxt = drive_idx + ((item_valid && !item_stall) ? 1 : 0);
			drive_idx <= nxt;
			if (item_valid && item_stall) begin
				// hold the stalled beat
			end else if (gap_left > 0) begin
				item_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (nxt < cmd_list.size()) begin
				item_valid <= 1'b1;
				command <= cmd_list[nxt].cmd;
				slot <= cmd_list[nxt].slot;
				data_word <= cmd_list[nxt].word;
				gap_left <= (nxt >= 600 && nxt < 800) ? 0 : $urandom_range(0, 10);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result monitor with random stall and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		list_resp_t want;
		int wait_cycles;
		if (!arst_n) begin
			result_stall <= 1'b1;
			stall_left <= 0;
			resp_seen <= 0;
		end else begin
			wait_cycles = stall_left;
			if (result_valid && !result_stall) begin
				if (resp_q.size() == 0) begin
					errors++;
					$display("unexpected result beat %0d", resp_seen);
				end else begin
					want = resp_q.pop_front();
					if (status !== want.status) report("status", status, want.status);
					if (new_slot !== want.new_slot) report("new_slot", new_slot, want.new_slot);
					if (read_word !== want.read_word) report("read_word", read_word, want.read_word);
					if (entry_count !== want.entry_count)
						report("entry_count", entry_count, want.entry_count);
				end
				resp_seen <= resp_seen + 1;
				if (resp_seen + 1 == HOLD_AT) wait_cycles = HOLD_CYCLES;
				else if (resp_seen >= 600 && resp_seen < 800) wait_cycles = 0;
				else wait_cycles = $urandom_range(0, 10);
			end
			if (wait_cycles > 0) begin
				result_stall <= 1'b1;
				stall_left <= wait_cycles - 1;
			end else begin
				result_stall <= 1'b0;
				stall_left <= 0;
			end
		end
	end

endmodule
